[design/srld_pkg.sv]
`default_nettype none

package srld_pkg;

    localparam int COORD_BITS = 12;

    localparam logic [12:0] WIDTH_MAX  = 13'(1 << COORD_BITS);
    localparam logic [11:0] HEIGHT_MAX = 12'((1 << COORD_BITS) - 1);

    localparam logic [9:0] CODE_MIN_ONE   = 10'h004;
    localparam logic [9:0] CODE_MIN_TWO   = 10'h010;
    localparam logic [9:0] CODE_MIN_THREE = 10'h040;

    localparam logic [3:0] CONTRAST_OPAQUE = 4'hf;
    localparam logic [3:0] CONTRAST_CLEAR  = 4'h0;
    localparam logic [7:0] GRAY_MAX        = 8'd255;
    localparam logic [8:0] GRAY_SPAN       = 9'd256;

    localparam logic [1:0] REG_AREA_WIDTH     = 2'd0;
    localparam logic [1:0] REG_AREA_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_LUMA_TABLE     = 2'd2;
    localparam logic [1:0] REG_CONTRAST_TABLE = 2'd3;

    typedef struct packed {
        logic [11:0] run_x;
        logic [11:0] run_y;
        logic [12:0] run_length;
        logic [7:0]  gray_level;
        logic [7:0]  alpha_level;
        logic        line_end;
        logic        next_field;
        logic        picture_done;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [5:0]  partial;
        logic [1:0]  held;
        logic [12:0] column;
        logic [11:0] line;
        logic        field;
    } dec_state_t;

    typedef struct packed {
        dec_state_t st;
        logic       emit;
        logic       ended;
        result_t    res;
    } nib_out_t;

    // Decodes one nibble against the running state and forms at most one run.
    function automatic nib_out_t take_nibble(
        input dec_state_t  st,
        input logic [3:0]  nib,
        input logic [12:0] w,
        input logic [11:0] h,
        input logic [31:0] luma,
        input logic [15:0] contrast
    );
        nib_out_t    o;
        logic [9:0]  code;
        logic [2:0]  held;
        logic        done;
        logic [1:0]  color;
        logic [12:0] remaining;
        logic [12:0] len;
        logic [12:0] col_next;
        logic [3:0]  c;
        logic [7:0]  alpha;
        logic [7:0]  gray;
        logic [8:0]  sum;
        o = '0;
        o.st = st;
        code = {st.partial, nib};
        held = {1'b0, st.held} + 3'd1;
        case (held)
            3'd1:    done = code >= CODE_MIN_ONE;
            3'd2:    done = code >= CODE_MIN_TWO;
            3'd3:    done = code >= CODE_MIN_THREE;
            default: done = 1'b1;
        endcase
        if (!done)
        begin
            o.st.partial = code[5:0];
            o.st.held    = held[1:0];
        end
        else
        begin
            o.st.partial = '0;
            o.st.held    = '0;
            color = ~code[1:0];
            remaining = (st.column < w) ? (w - st.column) : 13'd0;
            len = {5'd0, code[9:2]};
            if (len == 13'd0 || len > remaining)
            begin
                len = remaining;
            end
            c = contrast[{color, 2'b00} +: 4];
            if (c == CONTRAST_OPAQUE)
                alpha = 8'd1;
            else if (c == CONTRAST_CLEAR)
                alpha = 8'd0;
            else
                alpha = {~c, 4'b0000};
            gray = luma[{color, 3'b000} +: 8];
            sum = {1'b0, gray} + {1'b0, alpha};
            if (alpha == 8'd0)
                gray = 8'd0;
            else if (sum > {1'b0, GRAY_MAX})
                gray = 8'(GRAY_SPAN - {1'b0, alpha});
            o.emit = 1'b1;
            o.res.run_x       = st.column[11:0];
            o.res.run_y       = st.line;
            o.res.run_length  = len;
            o.res.gray_level  = gray;
            o.res.alpha_level = alpha;
            col_next = st.column + len;
            if (col_next >= w)
            begin
                o.st.column = '0;
                o.st.line   = st.line + 12'd1;
                o.st.field  = ~st.field;
                o.ended     = 1'b1;
            end
            else
            begin
                o.st.column = col_next;
            end
            o.res.line_end     = o.ended;
            o.res.next_field   = o.st.field;
            o.res.picture_done = o.st.line >= h;
            o.res.last         = 1'b0;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

[design/subpicture_rle_line_decoder.sv]
// The runs of an accepted byte are registered in the result queue and leave it in order.
// Throughput: one byte per cycle; a byte giving two runs needs two output beats, and a
// four-entry result queue takes a new byte while it has room for two runs.
// Reset (rst_n low, asynchronous) clears position, line, field, partial code, the
// registers and the queue.
`default_nettype none

module subpicture_rle_line_decoder
    import srld_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // new_picture
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // run_x, run_y, run_length, gray_level, alpha_level, line_end, next_field,
    // picture_done
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    logic [12:0] area_width_reg;
    logic [11:0] area_height_reg;
    logic [31:0] luma_table_reg;
    logic [15:0] contrast_table_reg;

    dec_state_t state_reg;
    dec_state_t state_next;

    result_t    fifo_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    logic [12:0] w;
    logic [11:0] h;
    dec_state_t  s0;
    nib_out_t    n0;
    nib_out_t    n1;
    logic        accept;
    logic        pop;
    logic        active;
    logic        emit0;
    logic        emit1;
    result_t     r0;
    result_t     r1;
    result_t     single;
    result_t     head;
    logic [2:0]  push_count;

    assign w = (area_width_reg > WIDTH_MAX) ? WIDTH_MAX : area_width_reg;
    assign h = (area_height_reg > HEIGHT_MAX) ? HEIGHT_MAX : area_height_reg;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = count_reg <= 3'd2;
    assign m_axis_tvalid = count_reg != 3'd0;

    always_comb
    begin
        s0 = s_axis_tuser ? dec_state_t'('0) : state_reg;
        active = s0.line < h;
        n0 = take_nibble(s0, s_axis_tdata[7:4], w, h, luma_table_reg, contrast_table_reg);
        n1 = take_nibble(n0.st, s_axis_tdata[3:0], w, h, luma_table_reg, contrast_table_reg);
        emit0 = active && n0.emit;
        emit1 = active && !n0.ended && n1.emit;
        r0 = n0.res;
        r0.last = !emit1;
        r1 = n1.res;
        r1.last = 1'b1;
        single = emit0 ? r0 : r1;
        push_count = {2'b00, emit0} + {2'b00, emit1};
        if (!accept)
            state_next = state_reg;
        else if (!active)
            state_next = s0;
        else if (n0.ended)
            state_next = n0.st;
        else
            state_next = n1.st;
    end

    assign head = fifo_reg[rd_ptr_reg];
    assign m_axis_tdata = {head.picture_done, head.next_field, head.line_end,
                           head.alpha_level, head.gray_level, head.run_length,
                           head.run_y, head.run_x};
    assign m_axis_tlast = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_width_reg     <= '0;
            area_height_reg    <= '0;
            luma_table_reg     <= '0;
            contrast_table_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AREA_WIDTH:     area_width_reg     <= cfg_data[12:0];
                REG_AREA_HEIGHT:    area_height_reg    <= cfg_data[11:0];
                REG_LUMA_TABLE:     luma_table_reg     <= cfg_data;
                REG_CONTRAST_TABLE: contrast_table_reg <= cfg_data[15:0];
                default:            area_width_reg     <= area_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + push_count[1:0];
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (accept ? push_count : 3'd0) - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit0 && emit1)
        begin
            fifo_reg[wr_ptr_reg]         <= r0;
            fifo_reg[wr_ptr_reg + 2'd1]  <= r1;
        end
        else if (accept && (emit0 || emit1))
        begin
            fifo_reg[wr_ptr_reg] <= single;
        end
    end

endmodule

`default_nettype wire

[verif/srld_run_checker.sv]
`default_nettype none

module srld_run_checker
    import srld_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // new_picture
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // run_x, run_y, run_length, gray_level, alpha_level, line_end, next_field,
    // picture_done
    input  wire logic [55:0] m_axis_tdata,
    input  wire logic        m_axis_tlast,
    output int               mismatches,
    output int               runs_pending,
    output logic             picture_over
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [12:0] width_reg;
    logic [11:0] height_reg;
    logic [31:0] luma_reg;
    logic [15:0] contrast_reg;

    logic [15:0] code_acc;
    logic [1:0]  nib_count;
    logic [12:0] col;
    logic [11:0] row;
    logic        fld;

    result_t runs_due[$];

    function automatic logic [11:0] height_cap();
        return (height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg;
    endfunction

    function automatic logic [7:0] alpha_of(input logic [3:0] c);
        if (c == CONTRAST_OPAQUE)
            return 8'd1;
        if (c == CONTRAST_CLEAR)
            return 8'd0;
        return {4'hf - c, 4'h0};
    endfunction

    task automatic feed_nibble(input logic [3:0] nib, output logic emitted,
                               output logic ended, output result_t r);
        logic [15:0] code;
        logic [2:0]  cnt;
        logic        done;
        logic [12:0] w;
        logic [12:0] remaining;
        logic [12:0] len;
        logic [12:0] next_col;
        logic [1:0]  color;
        logic [7:0]  alpha;
        logic [7:0]  gray;
        w = (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
        code = {code_acc[11:0], nib};
        cnt = {1'b0, nib_count} + 3'd1;
        emitted = 1'b0;
        ended = 1'b0;
        r = '0;
        case (cnt)
            3'd1:    done = code >= 16'(CODE_MIN_ONE);
            3'd2:    done = code >= 16'(CODE_MIN_TWO);
            3'd3:    done = code >= 16'(CODE_MIN_THREE);
            default: done = 1'b1;
        endcase
        if (!done)
        begin
            code_acc = code;
            nib_count = cnt[1:0];
            return;
        end
        code_acc = '0;
        nib_count = '0;
        color = 2'd3 - code[1:0];
        len = 13'(code >> 2);
        remaining = (col < w) ? w - col : 13'd0;
        if (len == 13'd0 || len > remaining)
            len = remaining;
        alpha = alpha_of(contrast_reg[4 * color +: 4]);
        gray = (alpha == 8'd0) ? 8'd0 : luma_reg[8 * color +: 8];
        if (alpha != 8'd0 && ({1'b0, gray} + {1'b0, alpha}) > 9'd255)
            gray = 8'(GRAY_SPAN - {1'b0, alpha});
        r.run_x = col[11:0];
        r.run_y = row;
        r.run_length = len;
        r.gray_level = gray;
        r.alpha_level = alpha;
        next_col = col + len;
        if (next_col >= w)
        begin
            col = '0;
            row = row + 12'd1;
            fld = ~fld;
            ended = 1'b1;
        end
        else
        begin
            col = next_col;
        end
        r.line_end = ended;
        r.next_field = fld;
        r.picture_done = row >= height_cap();
        r.last = 1'b0;
        emitted = 1'b1;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic restart);
        result_t r_hi;
        result_t r_lo;
        logic    got_hi;
        logic    got_lo;
        logic    end_hi;
        logic    end_lo;
        if (restart)
        begin
            code_acc = '0;
            nib_count = '0;
            col = '0;
            row = '0;
            fld = 1'b0;
        end
        if (row >= height_cap())
            return;
        feed_nibble(b[7:4], got_hi, end_hi, r_hi);
        got_lo = 1'b0;
        if (!end_hi && row < height_cap())
            feed_nibble(b[3:0], got_lo, end_lo, r_lo);
        if (got_lo)
        begin
            r_lo.last = 1'b1;
            if (got_hi)
                runs_due.push_back(r_hi);
            runs_due.push_back(r_lo);
        end
        else if (got_hi)
        begin
            r_hi.last = 1'b1;
            runs_due.push_back(r_hi);
        end
    endtask

    task automatic report_run(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s at %0t", what, $realtime);
            $display("  expected x=%0d y=%0d len=%0d gray=%0d alpha=%0d",
                     want.run_x, want.run_y, want.run_length, want.gray_level,
                     want.alpha_level);
            $display("           end=%0b field=%0b done=%0b last=%0b",
                     want.line_end, want.next_field, want.picture_done, want.last);
            $display("  actual   x=%0d y=%0d len=%0d gray=%0d alpha=%0d",
                     got.run_x, got.run_y, got.run_length, got.gray_level,
                     got.alpha_level);
            $display("           end=%0b field=%0b done=%0b last=%0b",
                     got.line_end, got.next_field, got.picture_done, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            width_reg = '0;
            height_reg = '0;
            luma_reg = '0;
            contrast_reg = '0;
            code_acc = '0;
            nib_count = '0;
            col = '0;
            row = '0;
            fld = 1'b0;
            runs_due.delete();
            mismatches = 0;
            runs_pending <= 0;
            picture_over <= 1'b1;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.run_x = m_axis_tdata[11:0];
                got.run_y = m_axis_tdata[23:12];
                got.run_length = m_axis_tdata[36:24];
                got.gray_level = m_axis_tdata[44:37];
                got.alpha_level = m_axis_tdata[52:45];
                got.line_end = m_axis_tdata[53];
                got.next_field = m_axis_tdata[54];
                got.picture_done = m_axis_tdata[55];
                got.last = m_axis_tlast;
                if (runs_due.size() == 0)
                begin
                    report_run("Output beat with no run expected", '0, got);
                end
                else
                begin
                    want = runs_due.pop_front();
                    if (got !== want)
                        report_run("Run mismatch", want, got);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AREA_WIDTH:     width_reg = cfg_data[12:0];
                    REG_AREA_HEIGHT:    height_reg = cfg_data[11:0];
                    REG_LUMA_TABLE:     luma_reg = cfg_data;
                    REG_CONTRAST_TABLE: contrast_reg = cfg_data[15:0];
                    default:            ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tuser);
            runs_pending <= runs_due.size();
            picture_over <= row >= height_cap();
        end
    end

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srld_pkg::*;

    localparam int ITEMS = 850;
    localparam int PHASES = 6;
    localparam int LIMIT = 300000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_AREA_WIDTH;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    int          mismatches;
    int          runs_pending;
    logic        picture_over;
    logic        calm = 1'b0;
    int unsigned cycles = 0;
    logic [3:0]  nib_stock[$];

    always #2 clk = ~clk;

    subpicture_rle_line_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    srld_run_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .runs_pending  (runs_pending),
        .picture_over  (picture_over)
    );

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(99) >= 19);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic restart);
        while (!calm && $urandom_range(99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= restart;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drains the decoder so that the registers can be changed while it is idle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (runs_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [12:0] w, input logic [11:0] h,
                              input logic [31:0] luma, input logic [15:0] contrast);
        cfg_we <= 1'b1;
        cfg_index <= REG_AREA_WIDTH;
        cfg_data <= {19'd0, w};
        @(posedge clk);
        cfg_index <= REG_AREA_HEIGHT;
        cfg_data <= {20'd0, h};
        @(posedge clk);
        cfg_index <= REG_LUMA_TABLE;
        cfg_data <= luma;
        @(posedge clk);
        cfg_index <= REG_CONTRAST_TABLE;
        cfg_data <= {16'd0, contrast};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Draws bytes from a stream of well-formed codes of one to four nibbles.
    task automatic next_coded_byte(output logic [7:0] b);
        logic [15:0] code;
        while (nib_stock.size() < 2)
        begin
            case ($urandom_range(4, 1))
                1:
                begin
                    code = 16'($urandom_range(15, 4));
                    nib_stock.push_back(code[3:0]);
                end
                2:
                begin
                    code = 16'($urandom_range(16'h3f, 16'h10));
                    nib_stock.push_back(code[7:4]);
                    nib_stock.push_back(code[3:0]);
                end
                3:
                begin
                    code = 16'($urandom_range(16'h0ff, 16'h040));
                    nib_stock.push_back(code[11:8]);
                    nib_stock.push_back(code[7:4]);
                    nib_stock.push_back(code[3:0]);
                end
                default:
                begin
                    if ($urandom_range(2) == 0)
                        code = 16'($urandom_range(3));
                    else
                        code = 16'($urandom_range(16'h3ff));
                    nib_stock.push_back(code[15:12]);
                    nib_stock.push_back(code[11:8]);
                    nib_stock.push_back(code[7:4]);
                    nib_stock.push_back(code[3:0]);
                end
            endcase
        end
        b[7:4] = nib_stock.pop_front();
        b[3:0] = nib_stock.pop_front();
    endtask

    task automatic random_bytes(input int count);
        logic [7:0] b;
        logic       restart;
        for (int i = 0; i < count; i++)
        begin
            restart = picture_over || ($urandom_range(99) < 2);
            if ($urandom_range(99) < 80)
                next_coded_byte(b);
            else
                b = 8'($urandom_range(255));
            send_byte(b, restart);
        end
    endtask

    initial
    begin
        logic [12:0] w;
        logic [11:0] h;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_regs(13'd16, 12'd6, 32'h20ff_80ff, 16'h1f80);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h0f, 1'b0);
        send_byte(8'h45, 1'b0);
        send_byte(8'h67, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h3f, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hff, 1'b1);
        drain();
        write_regs(13'd40, 12'd100, 32'h0000_0000, 16'h0000);
        send_byte(8'hcc, 1'b1);
        drain();
        write_regs(13'd3, 12'd100, 32'hff00_ff00, 16'h8421);
        send_byte(8'h44, 1'b0);
        drain();
        write_regs(13'd0, 12'd3, 32'h1234_5678, 16'h9abc);
        send_byte(8'h4f, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h70, 1'b0);
        drain();
        write_regs(13'd8191, 12'd4095, 32'hffff_ffff, 16'hffff);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    w = 13'($urandom_range(24, 1));
                    h = 12'($urandom_range(30, 1));
                end
                1:
                begin
                    w = WIDTH_MAX;
                    h = 12'($urandom_range(12, 1));
                end
                2:
                begin
                    w = 13'd0;
                    h = 12'($urandom_range(40, 1));
                end
                3:
                begin
                    w = 13'($urandom_range(8191, 4097));
                    h = HEIGHT_MAX;
                end
                default:
                begin
                    w = 13'($urandom_range(64, 1));
                    h = 12'($urandom_range(60, 1));
                end
            endcase
            write_regs(w, h, $urandom, 16'($urandom_range(16'hffff)));
            calm <= (p == 3);
            random_bytes(ITEMS / PHASES);
            drain();
        end
        write_regs(13'd16, 12'd0, 32'h0, 16'h0);
        send_byte(8'hab, 1'b0);
        send_byte(8'hab, 1'b1);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (runs_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
